FILE: design/sc2a_pkg.sv
// Package with shared types, key codes and translation tables for the scancode translator.
`timescale 1ns / 1ps

package sc2a_pkg;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Reset value of the page scroll register.
	localparam logic [4:0] PAGE_LINES_RESET = 5'd5;

	// Prefix and special bytes.
	localparam logic [7:0] BYTE_E0     = 8'hE0;
	localparam logic [7:0] BYTE_E1     = 8'hE1;
	localparam logic [7:0] BYTE_BREAK  = 8'h80;

	// Make codes of the keys that the front part handles itself.
	localparam logic [7:0] KEY_CTRL    = 8'h1D;
	localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
	localparam logic [7:0] KEY_RSHIFT  = 8'h36;
	localparam logic [7:0] KEY_ALT     = 8'h38;
	localparam logic [7:0] KEY_CAPS    = 8'h3A;
	localparam logic [7:0] KEY_NUM     = 8'h45;
	localparam logic [7:0] KEY_SCR     = 8'h46;
	localparam logic [7:0] KEY_UP      = 8'h48;
	localparam logic [7:0] KEY_PGUP    = 8'h49;
	localparam logic [7:0] KEY_DOWN    = 8'h50;
	localparam logic [7:0] KEY_PGDN    = 8'h51;
	localparam logic [7:0] KEY_TAB     = 8'h0F;

	// Break codes of the modifier and lock keys.
	localparam logic [7:0] KEY_CTRL_BRK   = KEY_CTRL | BYTE_BREAK;
	localparam logic [7:0] KEY_LSHIFT_BRK = KEY_LSHIFT | BYTE_BREAK;
	localparam logic [7:0] KEY_RSHIFT_BRK = KEY_RSHIFT | BYTE_BREAK;
	localparam logic [7:0] KEY_ALT_BRK    = KEY_ALT | BYTE_BREAK;
	localparam logic [7:0] KEY_CAPS_BRK   = KEY_CAPS | BYTE_BREAK;
	localparam logic [7:0] KEY_NUM_BRK    = KEY_NUM | BYTE_BREAK;
	localparam logic [7:0] KEY_SCR_BRK    = KEY_SCR | BYTE_BREAK;

	// Bounds of the two table regions.
	localparam logic [7:0] KEYPAD_FIRST = 8'h45;
	localparam logic [7:0] TABLE_END    = 8'h58;

	// Character codes used by the back part.
	localparam logic [6:0] CHAR_PAUSE   = 7'h05;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_C = 7'h63;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
	localparam logic [6:0] CTRL_OFFSET  = 7'h60;
	localparam logic [6:0] CASE_OFFSET  = 7'h20;

	localparam int TABLE_DEPTH = 88;

	// Unshifted character table.
	localparam logic [6:0] PLAIN_MAP [TABLE_DEPTH] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// Shifted character table; the keypad region holds the navigation meaning.
	localparam logic [6:0] SHIFT_MAP [TABLE_DEPTH] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// Prefix machine states.
	typedef enum logic [1:0] {
		PX_NONE,
		PX_E0,
		PX_E1,
		PX_PAUSE
	} prefix_t;

	// Modifier and lock flags.
	typedef struct packed {
		logic scr_held;
		logic caps_held;
		logic num_held;
		logic scr_lock;
		logic caps_lock;
		logic num_lock;
		logic rshift;
		logic lshift;
		logic rctrl;
		logic lctrl;
		logic ralt;
		logic lalt;
	} mod_flags_t;

	// What the back part has to do with an item.
	typedef enum logic [1:0] {
		WK_NONE,
		WK_PAUSE,
		WK_XLATE,
		WK_SCROLL
	} work_kind_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		work_kind_t  kind;
		logic [7:0]  code;
		logic        ext;
		logic        shift;
		logic        ctrl;
		logic        caps;
		logic        num;
		logic        scroll_up;
		logic        scroll_page;
		logic        window;
	} work_t;

endpackage

FILE: design/sc2a_front.sv
// Front part: prefix machine, modifier flags, focus bit and item classification.
`timescale 1ns / 1ps

module sc2a_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          scan_byte,
	output sc2a_pkg::work_t     work
);

	sc2a_pkg::prefix_t    prefix_q;
	sc2a_pkg::prefix_t    prefix_d;
	sc2a_pkg::mod_flags_t flags_q;
	sc2a_pkg::mod_flags_t flags_d;
	logic                 focus_q;
	logic                 focus_d;
	logic                 handle;
	logic                 ext;
	logic                 shift;

	assign shift = flags_q.lshift | flags_q.rshift;

	// Prefix decode, flag updates and classification of the current byte.
	always_comb begin
		prefix_d = prefix_q;
		flags_d  = flags_q;
		focus_d  = focus_q;
		handle   = 1'b0;
		ext      = 1'b0;

		work.kind        = sc2a_pkg::WK_NONE;
		work.code        = scan_byte;
		work.ext         = 1'b0;
		work.shift       = shift;
		work.ctrl        = flags_q.lctrl | flags_q.rctrl;
		work.caps        = flags_q.caps_lock;
		work.num         = flags_q.num_lock;
		work.scroll_up   = (scan_byte == sc2a_pkg::KEY_PGUP) ||
		                   (scan_byte == sc2a_pkg::KEY_UP);
		work.scroll_page = (scan_byte == sc2a_pkg::KEY_PGUP) ||
		                   (scan_byte == sc2a_pkg::KEY_PGDN);
		work.window      = focus_q;

		unique case (prefix_q)
			sc2a_pkg::PX_NONE: begin
				if (scan_byte == sc2a_pkg::BYTE_E0) begin
					prefix_d = sc2a_pkg::PX_E0;
				end else if (scan_byte == sc2a_pkg::BYTE_E1) begin
					prefix_d = sc2a_pkg::PX_E1;
				end else begin
					handle = 1'b1;
				end
			end
			sc2a_pkg::PX_E0: begin
				prefix_d = sc2a_pkg::PX_NONE;
				handle   = 1'b1;
				ext      = 1'b1;
			end
			sc2a_pkg::PX_E1: begin
				if ((scan_byte == sc2a_pkg::KEY_CTRL) ||
				    (scan_byte == sc2a_pkg::KEY_CTRL_BRK)) begin
					prefix_d = sc2a_pkg::PX_PAUSE;
				end else begin
					prefix_d = sc2a_pkg::PX_NONE;
				end
			end
			sc2a_pkg::PX_PAUSE: begin
				prefix_d = sc2a_pkg::PX_NONE;
				if (scan_byte == sc2a_pkg::KEY_NUM) begin
					work.kind = sc2a_pkg::WK_PAUSE;
				end
			end
			default: begin
				prefix_d = sc2a_pkg::PX_NONE;
			end
		endcase

		work.ext = ext;

		// Key handling for bytes that are not part of a prefix.
		if (handle) begin
			unique case (scan_byte)
				sc2a_pkg::KEY_ALT: begin
					if (ext) flags_d.ralt = 1'b1; else flags_d.lalt = 1'b1;
				end
				sc2a_pkg::KEY_CTRL: begin
					if (ext) flags_d.rctrl = 1'b1; else flags_d.lctrl = 1'b1;
				end
				sc2a_pkg::KEY_LSHIFT: flags_d.lshift = 1'b1;
				sc2a_pkg::KEY_RSHIFT: flags_d.rshift = 1'b1;
				sc2a_pkg::KEY_ALT_BRK: begin
					if (ext) flags_d.ralt = 1'b0; else flags_d.lalt = 1'b0;
				end
				sc2a_pkg::KEY_CTRL_BRK: begin
					if (ext) flags_d.rctrl = 1'b0; else flags_d.lctrl = 1'b0;
				end
				sc2a_pkg::KEY_LSHIFT_BRK: flags_d.lshift = 1'b0;
				sc2a_pkg::KEY_RSHIFT_BRK: flags_d.rshift = 1'b0;
				sc2a_pkg::KEY_NUM: begin
					if (!flags_q.num_held) begin
						flags_d.num_lock = ~flags_q.num_lock;
						flags_d.num_held = 1'b1;
					end
				end
				sc2a_pkg::KEY_CAPS: begin
					if (!flags_q.caps_held) begin
						flags_d.caps_lock = ~flags_q.caps_lock;
						flags_d.caps_held = 1'b1;
					end
				end
				sc2a_pkg::KEY_SCR: begin
					if (!flags_q.scr_held) begin
						flags_d.scr_lock = ~flags_q.scr_lock;
						flags_d.scr_held = 1'b1;
					end
				end
				sc2a_pkg::KEY_NUM_BRK:  flags_d.num_held  = 1'b0;
				sc2a_pkg::KEY_CAPS_BRK: flags_d.caps_held = 1'b0;
				sc2a_pkg::KEY_SCR_BRK:  flags_d.scr_held  = 1'b0;
				sc2a_pkg::KEY_TAB:      focus_d = ~focus_q;
				sc2a_pkg::KEY_PGUP,
				sc2a_pkg::KEY_PGDN,
				sc2a_pkg::KEY_UP,
				sc2a_pkg::KEY_DOWN: begin
					if (ext) work.kind = sc2a_pkg::WK_SCROLL;
				end
				default: work.kind = sc2a_pkg::WK_XLATE;
			endcase
		end
	end

	// State registers advance only when an item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= sc2a_pkg::PX_NONE;
			flags_q  <= '0;
			focus_q  <= 1'b0;
		end else if (take) begin
			prefix_q <= prefix_d;
			flags_q  <= flags_d;
			focus_q  <= focus_d;
		end
	end

endmodule

FILE: design/sc2a_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module sc2a_queue #(
	parameter int DEPTH = sc2a_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sc2a_pkg::work_t  push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output sc2a_pkg::work_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sc2a_pkg::work_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/sc2a_back.sv
// Back part: character translation, scroll commands and the output register.
`timescale 1ns / 1ps

module sc2a_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [4:0]       cfg_wr_data,
	input  logic             work_valid,
	input  sc2a_pkg::work_t  work,
	output logic             work_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             char_valid,
	output logic [6:0]       char_code,
	output logic             interrupt_request,
	output logic             scroll_valid,
	output logic             scroll_up,
	output logic [4:0]       scroll_lines,
	output logic             scroll_window
);

	logic [4:0] page_lines_q;
	logic       out_valid_q;
	logic [6:0] ch;
	logic [6:0] ch_table;
	logic       intr;
	logic [6:0] idx;

	logic       char_valid_q;
	logic [6:0] char_code_q;
	logic       intr_q;
	logic       scroll_valid_q;
	logic       scroll_up_q;
	logic [4:0] scroll_lines_q;
	logic       scroll_window_q;

	assign idx      = work.code[6:0];
	assign work_pop = work_valid && (!out_valid_q || !out_stall);

	// Table lookup with caps, num lock and ctrl letter codes applied.
	always_comb begin
		ch       = '0;
		ch_table = '0;
		intr     = 1'b0;
		unique case (work.kind)
			sc2a_pkg::WK_PAUSE: ch = sc2a_pkg::CHAR_PAUSE;
			sc2a_pkg::WK_XLATE: begin
				if (work.code < sc2a_pkg::KEYPAD_FIRST) begin
					ch_table = work.shift ? sc2a_pkg::SHIFT_MAP[idx] : sc2a_pkg::PLAIN_MAP[idx];
					ch = ch_table;
					if ((ch_table >= sc2a_pkg::CHAR_LOWER_A) &&
					    (ch_table <= sc2a_pkg::CHAR_LOWER_Z)) begin
						if (work.ctrl) begin
							if (ch_table == sc2a_pkg::CHAR_LOWER_C) begin
								intr = 1'b1;
								ch   = '0;
							end else begin
								ch = ch_table - sc2a_pkg::CTRL_OFFSET;
							end
						end else if (work.caps != work.shift) begin
							ch = ch_table - sc2a_pkg::CASE_OFFSET;
						end
					end
				end else if (work.code < sc2a_pkg::TABLE_END) begin
					if (!work.ext && (work.num != work.shift)) begin
						ch = sc2a_pkg::PLAIN_MAP[idx];
					end else begin
						ch = sc2a_pkg::SHIFT_MAP[idx];
					end
				end
			end
			default: ch = '0;
		endcase
	end

	// Page scroll register; the user writes it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_lines_q <= sc2a_pkg::PAGE_LINES_RESET;
		end else if (cfg_wr_en) begin
			page_lines_q <= cfg_wr_data;
		end
	end

	// Output valid: set on a pop, cleared once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded when a new item enters the register.
	always_ff @(posedge clk) begin
		if (work_pop) begin
			char_valid_q    <= (ch != '0);
			char_code_q     <= ch;
			intr_q          <= intr;
			scroll_valid_q  <= (work.kind == sc2a_pkg::WK_SCROLL);
			scroll_up_q     <= (work.kind == sc2a_pkg::WK_SCROLL) && work.scroll_up;
			if (work.kind == sc2a_pkg::WK_SCROLL) begin
				scroll_lines_q <= work.scroll_page ? page_lines_q : 5'd1;
			end else begin
				scroll_lines_q <= '0;
			end
			scroll_window_q <= (work.kind == sc2a_pkg::WK_SCROLL) && work.window;
		end
	end

	assign out_valid         = out_valid_q;
	assign char_valid        = char_valid_q;
	assign char_code         = char_code_q;
	assign interrupt_request = intr_q;
	assign scroll_valid      = scroll_valid_q;
	assign scroll_up         = scroll_up_q;
	assign scroll_lines      = scroll_lines_q;
	assign scroll_window     = scroll_window_q;

endmodule

FILE: design/scancode_set1_to_ascii_core.sv
// Top level of the set-1 scancode to ASCII translator.
`timescale 1ns / 1ps
//
// Input channel: one raw set-1 scancode byte per item on scan_byte, taken when
// in_valid is high and in_stall is low. Output channel: exactly one result
// item per input byte, offered with out_valid and taken when out_stall is low.
// A result carries an optional character (char_valid, char_code), a ctrl+c
// interrupt flag, or a scroll command (scroll_valid, scroll_up, scroll_lines,
// scroll_window). Prefix bytes and dropped bytes give an all-zero result.
// A taken byte goes through the queue into the output register, which raises
// out_valid. The front part updates the prefix, modifier and focus state in
// the cycle it takes a byte, so one byte can be taken every cycle while the
// queue is not full; the back part translates one item per cycle unless the
// output stalls. A queue of QUEUE_DEPTH items lies between them; the output is
// registered. When the receiver stalls, the output item holds, the queue fills
// and then in_stall rises until the output moves again. Reset clears control
// state, empties the queue and loads the page scroll register with five lines;
// cfg_wr_en writes it; the user uses it only while idle, unenforced by the block.

module scancode_set1_to_ascii_core #(
	parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       char_valid,
	output logic [6:0] char_code,
	output logic       interrupt_request,
	output logic       scroll_valid,
	output logic       scroll_up,
	output logic [4:0] scroll_lines,
	output logic       scroll_window
);

	sc2a_pkg::work_t front_work;
	sc2a_pkg::work_t head_work;
	logic            take;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	// Front part: classify each byte and update key state.
	sc2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.scan_byte (scan_byte),
		.work      (front_work)
	);

	// Queue between the two parts.
	sc2a_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_work),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_work)
	);

	// Back part: form the result and hold it for the receiver.
	sc2a_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.work_valid        (q_not_empty),
		.work              (head_work),
		.work_pop          (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.char_valid        (char_valid),
		.char_code         (char_code),
		.interrupt_request (interrupt_request),
		.scroll_valid      (scroll_valid),
		.scroll_up         (scroll_up),
		.scroll_lines      (scroll_lines),
		.scroll_window     (scroll_window)
	);

endmodule

FILE: design/sc2a_checker.sv
// Port-level checker for the scancode translator and its bind statement.
`timescale 1ns / 1ps

module sc2a_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       char_valid,
	input  logic [6:0] char_code,
	input  logic       interrupt_request,
	input  logic       scroll_valid,
	input  logic       scroll_up,
	input  logic [4:0] scroll_lines,
	input  logic       scroll_window
);

	// A stalled output item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_valid) &&
		$stable(char_code) && $stable(interrupt_request) && $stable(scroll_valid) &&
		$stable(scroll_up) && $stable(scroll_lines) && $stable(scroll_window))
		else $error("output item changed while stalled");

	// A character flag always comes with a nonzero code, and no code without it.
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_valid == (char_code != 7'd0)))
		else $error("char_valid and char_code disagree");

	// Scroll fields are zero unless a scroll command is issued.
	a_scroll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !scroll_valid |-> !scroll_up && (scroll_lines == 5'd0) &&
		!scroll_window)
		else $error("scroll fields set without a scroll command");

	// Character, interrupt and scroll outcomes exclude each other.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(char_valid && scroll_valid) && !(interrupt_request && char_valid) &&
		!(interrupt_request && scroll_valid))
		else $error("more than one kind of result in one item");

endmodule

bind scancode_set1_to_ascii_core sc2a_checker u_sc2a_checker (.*);

FILE: tb/sv/testbench.sv
// Testbench for the set-1 scancode translator: a directed keystroke table, then random keystrokes.
`timescale 1ns / 1ps

module testbench;
	import sc2a_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_ROWS = 26;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [4:0] PAGE_RESET_LINES = 5'd5;

	// Own copies of the two character tables, one entry per make code below 0x58.
	localparam logic [6:0] KEYMAP_PLAIN [88] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00
	};
	localparam logic [6:0] KEYMAP_SHIFT [88] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [7:0] MOD_KEYS [4] = '{KEY_CTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_ALT};
	localparam logic [7:0] LOCK_KEYS [3] = '{KEY_CAPS, KEY_NUM, KEY_SCR};
	localparam logic [7:0] SCROLL_KEYS [4] = '{KEY_UP, KEY_PGUP, KEY_DOWN, KEY_PGDN};

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		logic       interrupt_request;
		logic       scroll_valid;
		logic       scroll_up;
		logic [4:0] scroll_lines;
		logic       scroll_window;
	} scan_result_t;

	typedef struct packed {
		logic [7:0]   code;
		logic         fixed;
		scan_result_t result;
	} dir_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_SPARSE,
		STALL_SOLID
	} stall_mode_t;

	localparam scan_result_t NONE_RES = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] scan_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       char_valid;
	logic [6:0] char_code;
	logic       interrupt_request;
	logic       scroll_valid;
	logic       scroll_up;
	logic [4:0] scroll_lines;
	logic       scroll_window;

	// Travels with each driven byte: whether the table row fixes the result.
	logic         tbl_fixed = 1'b0;
	scan_result_t tbl_result = '0;

	// Predictor state and its copy of the page register.
	prefix_t    px_state = PX_NONE;
	mod_flags_t mods = '0;
	logic       focus_log = 1'b0;
	logic [4:0] page_lines = PAGE_RESET_LINES;

	scan_result_t pending_results [$];
	logic [7:0]   key_bytes [$];
	dir_row_t     dir_rows [DIR_ROWS];
	logic [4:0]   page_plan [PHASES];

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int n_scan = 0;
	int n_results = 0;
	int n_chars = 0;
	int n_scrolls = 0;
	int n_intr = 0;
	int seg_left = 0;
	stall_mode_t seg_mode = STALL_NONE;

	scancode_set1_to_ascii_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.scan_byte         (scan_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.char_valid        (char_valid),
		.char_code         (char_code),
		.interrupt_request (interrupt_request),
		.scroll_valid      (scroll_valid),
		.scroll_up         (scroll_up),
		.scroll_lines      (scroll_lines),
		.scroll_window     (scroll_window)
	);

	always #1 clk = ~clk;

	function automatic scan_result_t char_res(input logic [6:0] c);
		scan_result_t r;
		r = '0;
		r.char_valid = 1'b1;
		r.char_code = c;
		return r;
	endfunction

	function automatic scan_result_t scroll_res(input logic up, input logic [4:0] lines,
			input logic win);
		scan_result_t r;
		r = '0;
		r.scroll_valid = 1'b1;
		r.scroll_up = up;
		r.scroll_lines = lines;
		r.scroll_window = win;
		return r;
	endfunction

	// Character for a make code under the current modifiers; flags ctrl+c.
	function automatic logic [6:0] key_char(input logic [7:0] code, input logic ext,
			output logic intr);
		logic shift;
		logic ctrl;
		logic [6:0] ch;
		shift = mods.lshift | mods.rshift;
		ctrl = mods.lctrl | mods.rctrl;
		intr = 1'b0;
		ch = '0;
		if (code < KEYPAD_FIRST) begin
			ch = shift ? KEYMAP_SHIFT[code] : KEYMAP_PLAIN[code];
			if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
				if (ctrl) begin
					if (ch == CHAR_LOWER_C) begin
						intr = 1'b1;
						ch = '0;
					end else begin
						ch = ch - CTRL_OFFSET;
					end
				end else if (mods.caps_lock != shift) begin
					ch = ch - CASE_OFFSET;
				end
			end
		end else if (code < TABLE_END) begin
			// Keypad: the navigation meaning wins for extended codes, else unless num lock and shift disagree.
			if (ext || (mods.num_lock == shift))
				ch = KEYMAP_SHIFT[code];
			else
				ch = KEYMAP_PLAIN[code];
		end
		return ch;
	endfunction

	// Steps the predictor by one scan byte and returns the result it causes.
	function automatic scan_result_t predict_scan(input logic [7:0] b);
		scan_result_t r;
		logic [6:0] ch;
		logic intr;
		logic do_key;
		logic ext;
		r = '0;
		ch = '0;
		intr = 1'b0;
		do_key = 1'b0;
		ext = 1'b0;

		// Prefix machine.
		case (px_state)
			PX_NONE: begin
				if (b == BYTE_E0)
					px_state = PX_E0;
				else if (b == BYTE_E1)
					px_state = PX_E1;
				else
					do_key = 1'b1;
			end
			PX_E0: begin
				px_state = PX_NONE;
				do_key = 1'b1;
				ext = 1'b1;
			end
			PX_E1: begin
				px_state = (b == KEY_CTRL || b == KEY_CTRL_BRK) ? PX_PAUSE : PX_NONE;
			end
			default: begin
				px_state = PX_NONE;
				if (b == KEY_NUM)
					ch = CHAR_PAUSE;
			end
		endcase

		// Modifiers, locks, focus, scroll keys and characters.
		if (do_key) begin
			case (b)
				KEY_ALT: begin
					if (ext) mods.ralt = 1'b1;
					else mods.lalt = 1'b1;
				end
				KEY_CTRL: begin
					if (ext) mods.rctrl = 1'b1;
					else mods.lctrl = 1'b1;
				end
				KEY_LSHIFT: mods.lshift = 1'b1;
				KEY_RSHIFT: mods.rshift = 1'b1;
				KEY_ALT_BRK: begin
					if (ext) mods.ralt = 1'b0;
					else mods.lalt = 1'b0;
				end
				KEY_CTRL_BRK: begin
					if (ext) mods.rctrl = 1'b0;
					else mods.lctrl = 1'b0;
				end
				KEY_LSHIFT_BRK: mods.lshift = 1'b0;
				KEY_RSHIFT_BRK: mods.rshift = 1'b0;
				KEY_NUM: begin
					if (!mods.num_held) begin
						mods.num_lock = ~mods.num_lock;
						mods.num_held = 1'b1;
					end
				end
				KEY_CAPS: begin
					if (!mods.caps_held) begin
						mods.caps_lock = ~mods.caps_lock;
						mods.caps_held = 1'b1;
					end
				end
				KEY_SCR: begin
					if (!mods.scr_held) begin
						mods.scr_lock = ~mods.scr_lock;
						mods.scr_held = 1'b1;
					end
				end
				KEY_NUM_BRK: mods.num_held = 1'b0;
				KEY_CAPS_BRK: mods.caps_held = 1'b0;
				KEY_SCR_BRK: mods.scr_held = 1'b0;
				KEY_TAB: focus_log = ~focus_log;
				KEY_PGUP, KEY_PGDN, KEY_UP, KEY_DOWN: begin
					if (ext) begin
						r.scroll_valid = 1'b1;
						r.scroll_up = (b == KEY_PGUP || b == KEY_UP);
						r.scroll_lines = (b == KEY_PGUP || b == KEY_PGDN) ? page_lines : 5'd1;
						r.scroll_window = focus_log;
					end
				end
				default: ch = key_char(b, ext, intr);
			endcase
		end

		r.char_valid = (ch != 0);
		r.char_code = ch;
		r.interrupt_request = intr;
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compares one result from the block with the oldest expectation.
	task automatic check_result(input scan_result_t got);
		scan_result_t want;
		if (pending_results.size() == 0) begin
			$error("Result item with no scan byte waiting for it");
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			compare_field("char_valid", want.char_valid, got.char_valid);
			compare_field("char_code", want.char_code, got.char_code);
			compare_field("interrupt_request", want.interrupt_request, got.interrupt_request);
			compare_field("scroll_valid", want.scroll_valid, got.scroll_valid);
			compare_field("scroll_up", want.scroll_up, got.scroll_up);
			compare_field("scroll_lines", want.scroll_lines, got.scroll_lines);
			compare_field("scroll_window", want.scroll_window, got.scroll_window);
		end
	endtask

	// Watches both channels and the register port at each rising edge.
	always @(posedge clk) begin
		scan_result_t got;
		scan_result_t exp_res;
		if (arst_n) begin
			if (cfg_wr_en)
				page_lines = cfg_wr_data;
			if (out_valid && !out_stall) begin
				got.char_valid = char_valid;
				got.char_code = char_code;
				got.interrupt_request = interrupt_request;
				got.scroll_valid = scroll_valid;
				got.scroll_up = scroll_up;
				got.scroll_lines = scroll_lines;
				got.scroll_window = scroll_window;
				check_result(got);
				n_results++;
				if (char_valid) n_chars++;
				if (scroll_valid) n_scrolls++;
				if (interrupt_request) n_intr++;
			end
			if (in_valid && !in_stall) begin
				// The predictor follows every byte so its key state stays in step.
				exp_res = predict_scan(scan_byte);
				pending_results.push_back(tbl_fixed ? tbl_result : exp_res);
			end
		end
	end

	// Receiver stalls in segments: free, coin-flip, sparse or solid.
	always @(posedge clk) begin
		if (seg_left == 0) begin
			seg_mode = stall_mode_t'($urandom_range(0, 3));
			seg_left = (seg_mode == STALL_SOLID) ? $urandom_range(1, 10) : $urandom_range(5, 50);
		end
		seg_left--;
		case (seg_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= ($urandom_range(0, 1) == 0);
			STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= 1'b1;
		endcase
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one byte, with a random gap at the start of each burst, and waits for it.
	task automatic send_scan(input logic [7:0] b, input logic fixed, input scan_result_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		scan_byte <= b;
		tbl_fixed <= fixed;
		tbl_result <= r;
		do
			@(posedge clk);
		while (in_stall);
		n_scan++;
	endtask

	// Drains the block, lets it settle, then writes the page register.
	task automatic set_page_lines(input logic [4:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		burst_left = 0;
	endtask

	// Queues the bytes of one random keystroke; mostly well-formed, some noise.
	task automatic add_keystroke();
		int pick;
		logic [7:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// Ordinary key, sometimes released.
			k = 8'($urandom_range(1, 8'h57));
			key_bytes.push_back(k);
			if ($urandom_range(0, 1) == 0)
				key_bytes.push_back(k | BYTE_BREAK);
		end else if (pick < 45) begin
			// Modifier make or break; ctrl and alt also on their right-hand side.
			k = MOD_KEYS[$urandom_range(0, 3)];
			if ((k == KEY_CTRL || k == KEY_ALT) && $urandom_range(0, 1) == 0)
				key_bytes.push_back(BYTE_E0);
			key_bytes.push_back(($urandom_range(0, 1) == 0) ? k : (k | BYTE_BREAK));
		end else if (pick < 55) begin
			// Lock key, possibly auto-repeated while held.
			k = LOCK_KEYS[$urandom_range(0, 2)];
			key_bytes.push_back(k);
			if ($urandom_range(0, 2) == 0)
				key_bytes.push_back(k);
			if ($urandom_range(0, 3) != 0)
				key_bytes.push_back(k | BYTE_BREAK);
		end else if (pick < 70) begin
			// Extended scroll key, occasionally its break code.
			key_bytes.push_back(BYTE_E0);
			k = SCROLL_KEYS[$urandom_range(0, 3)];
			key_bytes.push_back(($urandom_range(0, 4) == 0) ? (k | BYTE_BREAK) : k);
		end else if (pick < 75) begin
			key_bytes.push_back(($urandom_range(0, 2) == 0) ? (KEY_TAB | BYTE_BREAK) : KEY_TAB);
		end else if (pick < 82) begin
			// Pause sequence with either middle byte.
			key_bytes.push_back(BYTE_E1);
			key_bytes.push_back(($urandom_range(0, 1) == 0) ? KEY_CTRL : KEY_CTRL_BRK);
			key_bytes.push_back(KEY_NUM);
		end else if (pick < 87) begin
			// Ctrl chord over the letter rows.
			key_bytes.push_back(KEY_CTRL);
			key_bytes.push_back(8'($urandom_range(8'h10, 8'h32)));
			key_bytes.push_back(KEY_CTRL_BRK);
		end else if (pick < 90) begin
			key_bytes.push_back(BYTE_E0);
			key_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			// Broken pause sequence.
			key_bytes.push_back(BYTE_E1);
			if ($urandom_range(0, 1) == 0)
				key_bytes.push_back(KEY_CTRL);
			key_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			key_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Stimulus: reset, directed table, then random keystrokes under several page settings.
	initial begin
		int sent;
		dir_rows = '{
			'{8'h1E, 1'b1, char_res(7'h61)},
			'{8'h00, 1'b1, NONE_RES},
			'{8'hFF, 1'b1, NONE_RES},
			'{BYTE_E0, 1'b1, NONE_RES},
			'{KEY_PGUP, 1'b1, scroll_res(1'b1, 5'd5, 1'b0)},
			'{BYTE_E0, 1'b1, NONE_RES},
			'{KEY_PGDN, 1'b1, scroll_res(1'b0, 5'd5, 1'b0)},
			'{BYTE_E0, 1'b1, NONE_RES},
			'{KEY_UP, 1'b1, scroll_res(1'b1, 5'd1, 1'b0)},
			'{KEY_TAB, 1'b1, NONE_RES},
			'{BYTE_E0, 1'b1, NONE_RES},
			'{KEY_DOWN, 1'b0, NONE_RES},
			'{KEY_UP, 1'b1, NONE_RES},
			'{BYTE_E1, 1'b1, NONE_RES},
			'{KEY_CTRL, 1'b1, NONE_RES},
			'{KEY_NUM, 1'b1, char_res(7'h05)},
			'{BYTE_E1, 1'b1, NONE_RES},
			'{KEY_LSHIFT, 1'b1, NONE_RES},
			'{KEY_CTRL, 1'b0, NONE_RES},
			'{8'h2E, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 1'b0, 5'd0, 1'b0}},
			'{KEY_CTRL_BRK, 1'b0, NONE_RES},
			'{BYTE_E0, 1'b1, NONE_RES},
			'{BYTE_E1, 1'b1, NONE_RES},
			'{KEY_LSHIFT, 1'b0, NONE_RES},
			'{8'h10, 1'b0, NONE_RES},
			'{KEY_LSHIFT_BRK, 1'b0, NONE_RES}
		};
		page_plan = '{5'd1, 5'd31, 5'd0, 5'($urandom_range(2, 30)), 5'd5};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the page register at its reset value.
		for (int i = 0; i < DIR_ROWS; i++)
			send_scan(dir_rows[i].code, dir_rows[i].fixed, dir_rows[i].result);

		for (int p = 0; p < PHASES; p++) begin
			set_page_lines(page_plan[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (key_bytes.size() == 0)
					add_keystroke();
				send_scan(key_bytes.pop_front(), 1'b0, NONE_RES);
				sent++;
			end
		end

		// Drain and give the block time to show any stray result.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d scan bytes over %0d page settings; checked %0d results.",
			n_scan, PHASES + 1, n_results);
		$display("Results held %0d characters, %0d scroll commands, %0d interrupt requests.",
			n_chars, n_scrolls, n_intr);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
